[hw/rtl/sbs_pkg.sv]
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared widths, reset values, codes and constants of the setpoint stepper.
// ----------------------------------------------------------------------------
package sbs_pkg;

  // Field widths
  localparam int unsigned CENTI_W   = 15;
  localparam int unsigned HALF_W    = 6;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned SCREEN_W  = 20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 20;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TIME       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SCREEN_TIME = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SCREEN_TIME = 2'd3;

  // Configuration reset values
  localparam logic [MS_W-1:0]     HOLD_TIME_RST       = 16'd250;
  localparam logic [MS_W-1:0]     WAIT_TIME_RST       = 16'd250;
  localparam logic [SCREEN_W-1:0] MIN_SCREEN_TIME_RST = 20'd500;
  localparam logic [SCREEN_W-1:0] MAX_SCREEN_TIME_RST = 20'd5000;

  // Action codes
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_SET  = 1'b1;

  // Press line bits
  localparam logic [1:0] PRESS_NONE = 2'b00;
  localparam logic [1:0] PRESS_INC  = 2'b01;
  localparam logic [1:0] PRESS_DEC  = 2'b10;

  // Level range in half degrees (15.0 to 25.0 degrees)
  localparam logic [HALF_W-1:0] HALF_LOW  = 6'd30;
  localparam logic [HALF_W-1:0] HALF_HIGH = 6'd50;

  // Idle counter saturation value
  localparam logic [SCREEN_W-1:0] IDLE_MAX = 20'hFFFFF;

  // Rounding: halves = floor((centi + 25) / 50), clamped to 30..50.
  // The low and high bounds are the biased values that map to 31 and 50.
  localparam logic signed [CENTI_W:0] ROUND_BIAS = 16'sd25;
  localparam logic signed [CENTI_W:0] ROUND_LOW  = 16'sd1550;
  localparam logic signed [CENTI_W:0] ROUND_HIGH = 16'sd2500;
  // 65536 / 50 rounded up; exact floor for biased values below 2500
  localparam int unsigned RECIP_W    = 11;
  localparam logic [RECIP_W-1:0] ROUND_RECIP = 11'd1311;
  localparam int unsigned ROUND_X_W  = 12;
  localparam int unsigned ROUND_SHIFT = 16;

endpackage

[hw/rtl/sbs_if.sv]
// ----------------------------------------------------------------------------
// sbs_if
// Valid/ready channels of the setpoint stepper: input items and results.
// ----------------------------------------------------------------------------
interface sbs_item_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   action;
  logic signed [sbs_pkg::CENTI_W-1:0]     target_centi;

  modport source (output valid, action, target_centi, input ready);
  modport sink   (input valid, action, target_centi, output ready);
endinterface

interface sbs_result_if;
  logic                          valid;
  logic                          ready;
  logic                          increase_press;
  logic                          decrease_press;
  logic [sbs_pkg::HALF_W-1:0]    target_half;
  logic [sbs_pkg::HALF_W-1:0]    level_half;

  modport source (output valid, increase_press, decrease_press, target_half, level_half,
                  input ready);
  modport sink   (input valid, increase_press, decrease_press, target_half, level_half,
                  output ready);
endinterface

[hw/rtl/setpoint_button_stepper.sv]
// ----------------------------------------------------------------------------
// setpoint_button_stepper
// Steps an appliance setpoint through its up/down buttons in half degrees.
// ----------------------------------------------------------------------------
// Takes one word per clock while results are taken: either a one millisecond tick
// or a new target in hundredths of a degree, and returns one result word per input
// word showing both button lines, the target and the assumed level after that word.
// An accepted word is held in an input register and, once the result register is
// free, a single pass of compare and small add logic updates the stepper state and
// loads the result register, so the block sustains one word per cycle while results
// are taken. The input register keeps taking a word while a result waits; the input
// stalls only when both registers are full.
// Configuration writes take effect at once and are expected while idle.
// ----------------------------------------------------------------------------
module setpoint_button_stepper (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sbs_pkg::CFG_DATA_W-1:0]    cfg_data,
  sbs_item_if.sink                          item,
  sbs_result_if.source                      result
);

  // Configuration registers
  logic [sbs_pkg::MS_W-1:0]     hold_time;
  logic [sbs_pkg::MS_W-1:0]     wait_time;
  logic [sbs_pkg::SCREEN_W-1:0] min_screen_time;
  logic [sbs_pkg::SCREEN_W-1:0] max_screen_time;

  // Input register
  logic                                in_valid;
  logic                                in_action;
  logic signed [sbs_pkg::CENTI_W-1:0]  in_centi;

  // Stepper state
  logic [sbs_pkg::HALF_W-1:0]   level, level_next;
  logic [sbs_pkg::HALF_W-1:0]   target, target_next;
  logic [sbs_pkg::HALF_W-1:0]   pending, pending_next;
  logic                         pending_valid, pending_valid_next;
  logic [sbs_pkg::SCREEN_W-1:0] idle_ms, idle_ms_next;
  logic [sbs_pkg::SCREEN_W-1:0] timer_count, timer_count_next;
  logic                         timer_armed, timer_armed_next;
  logic                         timer_release, timer_release_next;
  logic [1:0]                   press, press_next;

  // Result register
  logic out_valid;

  logic advance;
  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || !out_valid || result.ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time       <= sbs_pkg::HOLD_TIME_RST;
      wait_time       <= sbs_pkg::WAIT_TIME_RST;
      min_screen_time <= sbs_pkg::MIN_SCREEN_TIME_RST;
      max_screen_time <= sbs_pkg::MAX_SCREEN_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbs_pkg::CFG_HOLD_TIME:       hold_time       <= cfg_data[sbs_pkg::MS_W-1:0];
        sbs_pkg::CFG_WAIT_TIME:       wait_time       <= cfg_data[sbs_pkg::MS_W-1:0];
        sbs_pkg::CFG_MIN_SCREEN_TIME: min_screen_time <= cfg_data[sbs_pkg::SCREEN_W-1:0];
        sbs_pkg::CFG_MAX_SCREEN_TIME: max_screen_time <= cfg_data[sbs_pkg::SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted word until it advances
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_action <= item.action;
      in_centi  <= item.target_centi;
    end
  end

  // Round the requested target to half degrees and clamp to 30..50
  logic signed [sbs_pkg::CENTI_W:0]                   biased;
  logic [sbs_pkg::ROUND_X_W+sbs_pkg::RECIP_W-1:0]     round_prod;
  logic [sbs_pkg::HALF_W-1:0]                         round_half;

  assign biased     = {in_centi[sbs_pkg::CENTI_W-1], in_centi} + sbs_pkg::ROUND_BIAS;
  assign round_prod = {{sbs_pkg::RECIP_W{1'b0}}, biased[sbs_pkg::ROUND_X_W-1:0]}
                      * {{sbs_pkg::ROUND_X_W{1'b0}}, sbs_pkg::ROUND_RECIP};

  always_comb begin
    priority if (biased < sbs_pkg::ROUND_LOW) begin
      round_half = sbs_pkg::HALF_LOW;
    end else if (biased >= sbs_pkg::ROUND_HIGH) begin
      round_half = sbs_pkg::HALF_HIGH;
    end else begin
      round_half = round_prod[sbs_pkg::ROUND_SHIFT +: sbs_pkg::HALF_W];
    end
  end

  // Update the stepper state for one word
  logic set_up;
  assign set_up = round_half > level;

  always_comb begin
    level_next         = level;
    target_next        = target;
    pending_next       = pending;
    pending_valid_next = pending_valid;
    idle_ms_next       = idle_ms;
    timer_count_next   = timer_count;
    timer_armed_next   = timer_armed;
    timer_release_next = timer_release;
    press_next         = press;

    if (advance) begin
      if (in_action == sbs_pkg::ACT_TICK) begin
        // Count idle time, then run the one-shot timer
        if (idle_ms < sbs_pkg::IDLE_MAX) begin
          idle_ms_next = idle_ms + 1'b1;
        end
        if (timer_armed) begin
          if (timer_count <= sbs_pkg::SCREEN_W'(1)) begin
            timer_armed_next = 1'b0;
            timer_count_next = '0;
            if (timer_release) begin
              // Release: drop both lines, rearm a press if more steps remain
              press_next   = sbs_pkg::PRESS_NONE;
              idle_ms_next = '0;
              if (level != target || pending_valid) begin
                timer_count_next   = sbs_pkg::SCREEN_W'(wait_time);
                timer_armed_next   = 1'b1;
                timer_release_next = 1'b0;
              end
              if (pending_valid) begin
                target_next        = pending;
                pending_valid_next = 1'b0;
              end
            end else begin
              // Press: step toward the target, arm the release
              if (level > target) begin
                level_next = level - 1'b1;
                press_next = press | sbs_pkg::PRESS_DEC;
              end else if (level < target) begin
                level_next = level + 1'b1;
                press_next = press | sbs_pkg::PRESS_INC;
              end
              timer_count_next   = sbs_pkg::SCREEN_W'(hold_time);
              timer_armed_next   = 1'b1;
              timer_release_next = 1'b1;
            end
          end else begin
            timer_count_next = timer_count - 1'b1;
          end
        end
      end else if (level != target) begin
        // Still stepping: park the new target
        pending_next       = round_half;
        pending_valid_next = 1'b1;
      end else begin
        target_next = round_half;
        if (round_half != level) begin
          priority if (idle_ms > max_screen_time) begin
            // Wake press then real press: level ends where it was
            press_next         = press | (set_up ? sbs_pkg::PRESS_INC : sbs_pkg::PRESS_DEC);
            timer_count_next   = sbs_pkg::SCREEN_W'(hold_time);
            timer_armed_next   = 1'b1;
            timer_release_next = 1'b1;
          end else if (idle_ms < min_screen_time) begin
            // Display awake: press at once
            level_next         = set_up ? level + 1'b1 : level - 1'b1;
            press_next         = press | (set_up ? sbs_pkg::PRESS_INC : sbs_pkg::PRESS_DEC);
            timer_count_next   = sbs_pkg::SCREEN_W'(hold_time);
            timer_armed_next   = 1'b1;
            timer_release_next = 1'b1;
          end else begin
            // Unsure: count the wake press, wait until the display surely sleeps
            level_next         = set_up ? level - 1'b1 : level + 1'b1;
            timer_count_next   = max_screen_time - idle_ms;
            timer_armed_next   = 1'b1;
            timer_release_next = 1'b0;
          end
        end
      end
    end
  end

  // Commit the stepper state
  always_ff @(posedge clk) begin
    if (rst) begin
      level         <= sbs_pkg::HALF_LOW;
      target        <= sbs_pkg::HALF_LOW;
      pending       <= '0;
      pending_valid <= 1'b0;
      idle_ms       <= '0;
      timer_count   <= '0;
      timer_armed   <= 1'b0;
      timer_release <= 1'b0;
      press         <= sbs_pkg::PRESS_NONE;
    end else begin
      level         <= level_next;
      target        <= target_next;
      pending       <= pending_next;
      pending_valid <= pending_valid_next;
      idle_ms       <= idle_ms_next;
      timer_count   <= timer_count_next;
      timer_armed   <= timer_armed_next;
      timer_release <= timer_release_next;
      press         <= press_next;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.increase_press <= press_next[0];
      result.decrease_press <= press_next[1];
      result.target_half    <= target_next;
      result.level_half     <= level_next;
    end
  end

  assign result.valid = out_valid;

  // A disarmed timer always sits at zero
  a_timer_idle_zero: assert property (@(posedge clk) disable iff (rst)
    !timer_armed |-> timer_count == '0)
    else $error("timer count nonzero while disarmed");

  // Target stays inside 15..25 degrees
  a_target_range: assert property (@(posedge clk) disable iff (rst)
    target >= sbs_pkg::HALF_LOW && target <= sbs_pkg::HALF_HIGH)
    else $error("target out of range");

  // Level never strays more than one wake step outside the target range
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level >= sbs_pkg::HALF_LOW - 1'b1 && level <= sbs_pkg::HALF_HIGH + 1'b1)
    else $error("level out of range");

  // A held word that advances always yields a result next cycle
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced word produced no result");

  // The result register is refilled only when the sink side is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |-> !advance)
    else $error("pending result overwritten");

endmodule
